>>> src/reiq_pkg.sv
// ----------------------------------------------------------------------------
// reiq_pkg: shared types and constants for the rotary encoder qualifier
// Request payload types, request kinds, gesture codes, register indexes and
// configuration reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package reiq_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned StepWidth     = 20;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 16;

  // Request kinds.
  localparam logic [2:0] KIND_EDGE       = 3'd0;
  localparam logic [2:0] KIND_FALL       = 3'd1;
  localparam logic [2:0] KIND_POLL       = 3'd2;
  localparam logic [2:0] KIND_READ_EVENT = 3'd3;
  localparam logic [2:0] KIND_READ_STEP  = 3'd4;

  // Gesture codes.
  localparam logic [1:0] GEST_NONE   = 2'd0;
  localparam logic [1:0] GEST_SHORT  = 2'd1;
  localparam logic [1:0] GEST_LONG   = 2'd2;
  localparam logic [1:0] GEST_DOUBLE = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_LONG_PRESS   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_DOUBLE_CLICK = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_ACCEL_THRESH = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_ACCEL_MULT   = 3'd4;

  localparam logic [15:0] DebounceRst    = 16'd20;
  localparam logic [15:0] LongPressRst   = 16'd1000;
  localparam logic [15:0] DoubleClickRst = 16'd300;
  localparam logic [14:0] AccelThreshRst = 15'd50;
  localparam logic [4:0]  AccelMultRst   = 5'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic        phase_a;
    logic        phase_b;
    logic        button_high;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                  gesture;
    logic signed [StepWidth-1:0] step_value;
  } out_item_t;

endpackage : reiq_pkg

`default_nettype wire

>>> src/rotary_encoder_input_qualifier_core.sv
// ----------------------------------------------------------------------------
// Rotary encoder input qualifier
// Qualifies encoder edges and button events into a saturating rotation count
// and click gestures, and answers read requests for gestures and steps.
// ----------------------------------------------------------------------------
// A result is registered into out_data_o, or into the skid entry while the
// output is stalled. One request per cycle while in_stall_o is low, as all
// state updates are done in a single pass from the request to the state and
// result registers. A two-entry output buffer accepts while one result waits.
// Reset clears the count, timestamps, button and gesture state, and loads the
// configuration registers with their default values.
`default_nettype none

module rotary_encoder_input_qualifier_core
  import reiq_pkg::*;
#(
  parameter int unsigned CountWidth = CountWidthDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_stall_o,
  input  wire in_item_t                in_data_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      out_item_t               out_data_o,
  input  wire logic                    cfg_valid_i,
  output      logic                    cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  localparam int unsigned MagWidth  = (CountWidth + 1 > 16) ? CountWidth + 1 : 16;
  localparam int unsigned ProdWidth = CountWidth + 6;
  localparam int unsigned SatWidth  = (ProdWidth > StepWidth + 1) ? ProdWidth : StepWidth + 1;

  localparam logic signed [CountWidth-1:0] CountMax = {1'b0, {(CountWidth-1){1'b1}}};
  localparam logic signed [CountWidth-1:0] CountMin = {1'b1, {(CountWidth-1){1'b0}}};
  localparam logic signed [SatWidth-1:0] StepMax =
    SatWidth'({1'b0, {(StepWidth-1){1'b1}}});
  localparam logic signed [SatWidth-1:0] StepMin =
    -StepMax - SatWidth'(1);

  // Configuration registers.
  logic [15:0] debounce_q, long_press_q, double_click_q;
  logic [14:0] accel_thresh_q;
  logic [4:0]  accel_mult_q;

  // Qualifier state.
  logic signed [CountWidth-1:0] count_q, count_d;
  logic [31:0] last_edge_q, last_edge_d;
  logic [31:0] press_start_q, press_start_d;
  logic        held_q, held_d;
  logic [31:0] last_click_q, last_click_d;
  logic        click_pend_q, click_pend_d;
  logic [1:0]  pend_gest_q, pend_gest_d;
  logic        gest_ready_q, gest_ready_d;

  // Output buffer.
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;
  out_item_t res;

  logic accept;
  logic out_free;

  logic [31:0]                  dur, since_click;
  logic [MagWidth-1:0]          mag;
  logic signed [ProdWidth-1:0]  prod;
  logic signed [SatWidth-1:0]   prod_ext;
  logic signed [SatWidth-1:0]   step_sel;
  logic signed [StepWidth-1:0]  step;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= DebounceRst;
      long_press_q   <= LongPressRst;
      double_click_q <= DoubleClickRst;
      accel_thresh_q <= AccelThreshRst;
      accel_mult_q   <= AccelMultRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE:     debounce_q     <= cfg_data_i;
        REG_LONG_PRESS:   long_press_q   <= cfg_data_i;
        REG_DOUBLE_CLICK: double_click_q <= cfg_data_i;
        REG_ACCEL_THRESH: accel_thresh_q <= cfg_data_i[14:0];
        REG_ACCEL_MULT:   accel_mult_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Step value: magnitude test, multiply, then clamp to the step range.
  always_comb begin
    if (count_q < 0) begin
      mag = MagWidth'(-($signed({count_q[CountWidth-1], count_q})));
    end else begin
      mag = MagWidth'(count_q);
    end
    prod     = $signed({{6{count_q[CountWidth-1]}}, count_q}) *
               $signed({{(ProdWidth-5){1'b0}}, accel_mult_q});
    prod_ext = SatWidth'(prod);
    if (mag > MagWidth'(accel_thresh_q)) begin
      step_sel = prod_ext;
    end else begin
      step_sel = $signed({{(SatWidth-CountWidth){count_q[CountWidth-1]}}, count_q});
    end
    // A wide count can exceed the step range even without multiplication.
    if (step_sel > StepMax) begin
      step = StepMax[StepWidth-1:0];
    end else if (step_sel < StepMin) begin
      step = StepMin[StepWidth-1:0];
    end else begin
      step = step_sel[StepWidth-1:0];
    end
  end

  always_comb begin
    count_d        = count_q;
    last_edge_d    = last_edge_q;
    press_start_d  = press_start_q;
    held_d         = held_q;
    last_click_d   = last_click_q;
    click_pend_d   = click_pend_q;
    pend_gest_d    = pend_gest_q;
    gest_ready_d   = gest_ready_q;
    res.gesture    = GEST_NONE;
    res.step_value = '0;
    dur            = in_data_i.now_ms - press_start_q;
    since_click    = '0;

    unique case (in_data_i.kind)
      KIND_EDGE: begin
        if (in_data_i.now_ms != last_edge_q) begin
          if (in_data_i.phase_a == in_data_i.phase_b) begin
            if (count_q != CountMax) count_d = count_q + CountWidth'(1);
          end else begin
            if (count_q != CountMin) count_d = count_q - CountWidth'(1);
          end
          last_edge_d = in_data_i.now_ms;
        end
      end
      KIND_FALL: begin
        if (!held_q) begin
          held_d        = 1'b1;
          press_start_d = in_data_i.now_ms;
        end
      end
      KIND_POLL: begin
        if (held_q && in_data_i.button_high) begin
          held_d = 1'b0;
          since_click = in_data_i.now_ms - last_click_q;
          if (dur < {16'd0, debounce_q}) begin
            click_pend_d = 1'b0;
          end else if (dur >= {16'd0, long_press_q}) begin
            pend_gest_d  = GEST_LONG;
            gest_ready_d = 1'b1;
            click_pend_d = 1'b0;
          end else if (click_pend_q && since_click < {16'd0, double_click_q}) begin
            pend_gest_d  = GEST_DOUBLE;
            gest_ready_d = 1'b1;
            click_pend_d = 1'b0;
          end else begin
            click_pend_d = 1'b1;
            last_click_d = in_data_i.now_ms;
          end
        end
        // The timeout check sees the updated click state; a bounce release
        // has already cleared click_pend_d, so it never fires there.
        if (click_pend_d &&
            (in_data_i.now_ms - last_click_d) > {16'd0, double_click_q}) begin
          pend_gest_d  = GEST_SHORT;
          gest_ready_d = 1'b1;
          click_pend_d = 1'b0;
        end
      end
      KIND_READ_EVENT: begin
        if (gest_ready_q) begin
          res.gesture  = pend_gest_q;
          pend_gest_d  = GEST_NONE;
          gest_ready_d = 1'b0;
        end
      end
      KIND_READ_STEP: begin
        res.step_value = step;
        count_d        = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      last_edge_q   <= '0;
      press_start_q <= '0;
      held_q        <= 1'b0;
      last_click_q  <= '0;
      click_pend_q  <= 1'b0;
      pend_gest_q   <= GEST_NONE;
      gest_ready_q  <= 1'b0;
    end else if (accept) begin
      count_q       <= count_d;
      last_edge_q   <= last_edge_d;
      press_start_q <= press_start_d;
      held_q        <= held_d;
      last_click_q  <= last_click_d;
      click_pend_q  <= click_pend_d;
      pend_gest_q   <= pend_gest_d;
      gest_ready_q  <= gest_ready_d;
    end
  end

  // The skid entry holds a result that arrived while the output was stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry occupied while output register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.kind == KIND_READ_STEP |=> count_q == '0)
    else $error("rotation count not cleared by a step read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !gest_ready_q |-> pend_gest_q == GEST_NONE)
    else $error("pending gesture held without ready flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(held_q) |-> $past(accept && in_data_i.kind == KIND_POLL))
    else $error("button hold released outside a poll");

endmodule : rotary_encoder_input_qualifier_core

`default_nettype wire
